### sv/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque
// Action and status codes, the slot type passed between cells and the
// per-cycle operation that every cell of the chain carries out.
// ---------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int FILL_W = 4;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [FILL_W-1:0]        t_fill;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // what each cell does this cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_RIGHT,  // take the left neighbor (push front)
        OP_SHIFT_LEFT,   // take the right neighbor (pop front)
        OP_WRITE_BACK,   // first empty cell takes the push value
        OP_CLEAR_BACK    // last full cell empties itself
    } t_cell_op;

    typedef struct packed {
        logic  valid;
        t_data data;
    } t_slot;

endpackage

### sv/circular_deque_top.sv
// ---------------------------------------------------------------------------
// circular_deque_top: fixed-capacity double-ended queue
// A row of CAPACITY cells with the front at cell 0. Push/pop at the front
// shift the whole row; push/pop at the back touch the boundary cell only.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-----------------------------------
//   in      | i_in_valid   | o_in_stall   | i_action, i_push_value
//   out     | o_out_valid  | i_out_stall  | o_pop_value, o_status, o_fill_count
//
// One beat per cycle while the input is not stalled: an action updates the
// cells and its result enters the output register at the same accepting edge.
// The input stalls only while a result waits and the output is stalled.
// Sync reset empties the deque (valid bits only) and drops any pending result.
// Pop-back reads the last full cell through a one-hot select across the row.
// ---------------------------------------------------------------------------
module circular_deque_top #(
    parameter int CAPACITY = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cdq_pkg::t_action i_action,
    input  cdq_pkg::t_data   i_push_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cdq_pkg::t_data   o_pop_value,
    output cdq_pkg::t_status o_status,
    output cdq_pkg::t_fill   o_fill_count
);
    import cdq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_slot              w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_last;
    t_cell_op           w_op;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_data              w_back;
    t_data              n_pop;
    t_status            n_status;
    logic [OCC_W-1:0]   n_occ;
    logic [OCC_W+FILL_W-1:0] w_occ_ext;

    logic               r_out_valid;
    t_data              r_pop;
    t_status            r_status;
    t_fill              r_fill;
    logic [OCC_W-1:0]   r_occ;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = w_valid[CAPACITY-1];
    assign w_empty    = !w_valid[0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;

        if (g == 0) begin : g_head
            assign w_left = '{valid: 1'b1, data: i_push_value};
        end else begin : g_mid
            assign w_left = w_slot[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '{valid: 1'b0, data: '0};
        end else begin : g_body
            assign w_right = w_slot[g+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_push_value (i_push_value),
            .i_left       (w_left),
            .i_right      (w_right),
            .o_slot       (w_slot[g]),
            .o_last       (w_last[g])
        );

        assign w_valid[g] = w_slot[g].valid;
    end

    // last full cell is one-hot (or none when empty)
    always_comb begin
        w_back = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_last[i]) begin
                w_back = w_back | w_slot[i].data;
            end
        end
    end

    always_comb begin
        w_op     = OP_HOLD;
        n_pop    = '0;
        n_status = ST_OK;
        n_occ    = r_occ;
        unique case (i_action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op  = (i_action == ACT_PUSH_FRONT) ? OP_SHIFT_RIGHT : OP_WRITE_BACK;
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_op  = (i_action == ACT_POP_FRONT) ? OP_SHIFT_LEFT : OP_CLEAR_BACK;
                    n_pop = (i_action == ACT_POP_FRONT) ? w_slot[0].data : w_back;
                    n_occ = r_occ - OCC_W'(1);
                end
            end
            default: w_op = OP_HOLD;
        endcase
        if (!w_accept) begin
            w_op = OP_HOLD;
        end
    end

    assign w_occ_ext = {{FILL_W{1'b0}}, n_occ};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_occ       <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_occ       <= n_occ;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop    <= n_pop;
            r_status <= n_status;
            r_fill   <= w_occ_ext[FILL_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pop_value  = r_pop;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

    // the count tracks the chain's valid bits
    a_occ_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_occ))
        else $error("occupancy differs from number of full cells");

    // full cells form a prefix of the row
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_last) <= 1 && (w_valid[0] || w_valid == '0))
        else $error("cell valid bits not contiguous");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_FULL |-> r_occ == OCC_W'(CAPACITY))
        else $error("full status while deque not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_EMPTY |-> r_occ == '0 && r_pop == '0)
        else $error("empty status while deque holds data");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_occ) && $stable(w_valid))
        else $error("state changed without an accepted beat");

endmodule

### sv/cdq_cell.sv
// ---------------------------------------------------------------------------
// cdq_cell: one element of the deque chain
// Holds one slot and its valid bit; moves data to or from its neighbors
// as the shared operation tells it. Full cells always form a prefix.
// ---------------------------------------------------------------------------
module cdq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdq_pkg::t_cell_op i_op,
    input  cdq_pkg::t_data    i_push_value,
    input  cdq_pkg::t_slot    i_left,
    input  cdq_pkg::t_slot    i_right,
    output cdq_pkg::t_slot    o_slot,
    output logic              o_last
);
    import cdq_pkg::*;

    logic  r_valid;
    t_data r_data;

    assign o_slot = '{valid: r_valid, data: r_data};
    assign o_last = r_valid && !i_right.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_op)
                OP_SHIFT_RIGHT: r_valid <= i_left.valid;
                OP_SHIFT_LEFT:  r_valid <= i_right.valid;
                OP_WRITE_BACK: begin
                    if (i_left.valid && !r_valid) begin
                        r_valid <= 1'b1;
                    end
                end
                OP_CLEAR_BACK: begin
                    if (o_last) begin
                        r_valid <= 1'b0;
                    end
                end
                default: r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_SHIFT_RIGHT: r_data <= i_left.data;
            OP_SHIFT_LEFT:  r_data <= i_right.data;
            OP_WRITE_BACK: begin
                if (i_left.valid && !r_valid) begin
                    r_data <= i_push_value;
                end
            end
            default: r_data <= r_data;
        endcase
    end

endmodule
